@@ design/vag_pkg.sv @@
// Shared types, constants and the PCM conversion function for the voice
// activity recording gate. Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package vag_pkg;

    // Field widths.
    localparam int SAMPLE_W  = 24;
    localparam int PCM_W     = 16;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 8;

    // Default block length.
    localparam int BLOCK_MAX_DEF = 64;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LIMIT = 8'd1;

    // Register reset values.
    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 24'd104858;
    localparam logic [CFG_W-1:0] SILENCE_RESET   = 24'd16000;

    // Saturation value of the silence count.
    localparam logic [CFG_W-1:0] SILENCE_SAT = 24'hFFFFFF;

    // Decision taken at the end of a block.
    typedef struct packed {
        logic keep;
        logic started;
        logic stopped;
    } gate_dec_t;

    // Clamp a Q4.20 sample to [-1, 1], scale by 32767 and divide by 2^20,
    // truncating toward zero.
    function automatic logic signed [PCM_W-1:0] to_pcm(input logic signed [SAMPLE_W-1:0] s);
        logic signed [21:0] c;
        logic signed [37:0] prod;
        logic signed [37:0] adj;
        if (s > 24'sd1048576) begin
            c = 22'sd1048576;
        end else if (s < -24'sd1048576) begin
            c = -22'sd1048576;
        end else begin
            c = s[21:0];
        end
        prod = c * 16'sd32767;
        // Negative products get a bias so the shift rounds toward zero.
        adj = prod[37] ? (prod + 38'sd1048575) : prod;
        return adj[35:20];
    endfunction

endpackage

@@ design/voice_activity_recording_gate_core.sv @@
// Top level of the voice activity recording gate: capture into the block
// store, replay of kept blocks as PCM. Depends on vag_pkg, vag_store, vag_gate.
`timescale 1ns / 1ps

// Usage
// The s_ channel carries Q4.20 samples with a block_last mark; the m_ channel
// returns 16-bit PCM for every kept block, in store order, with run_last on
// the final sample and utterance_start / utterance_end flags. The cfg_ port
// writes the threshold (index 0) and silence limit (index 1); the user must
// do so only while idle, as the block itself does not enforce it.
// Throughput: one sample per cycle is taken while a block is captured. When
// a kept block ends, input pauses while the store is replayed through its
// single read port, one sample per cycle while m_ready stays high.
// After a kept block's last sample, the sequencer enters replay and the first
// result passes the store read register, then the output register.
// Reset (aresetn low, synchronous) clears the fill count, peak, recording
// flag, silence count, replay sequencer and output valid, and reloads the
// register defaults; store contents need no clearing.
// A stalled receiver holds the output register and the read stage; replay
// resumes when m_ready returns, and input stays paused until the replay ends.
module voice_activity_recording_gate_core
    import vag_pkg::*;
#(
    parameter int BLOCK_MAX = BLOCK_MAX_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_value,
    input  logic                       s_block_last,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [PCM_W-1:0]    m_pcm_sample,
    output logic                       m_run_last,
    output logic                       m_utterance_start,
    output logic                       m_utterance_end
);

    localparam int AW = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;
    localparam int CW = $clog2(BLOCK_MAX + 1);

    localparam logic ST_CAPTURE = 1'b0;
    localparam logic ST_REPLAY  = 1'b1;

    logic                state_reg;
    logic [AW-1:0]       fill_reg;
    logic [CW-1:0]       len_reg;
    logic [AW-1:0]       rd_idx_reg;
    logic                start_reg;
    logic                stop_reg;
    logic                rd_valid_reg;
    logic                rd_first_reg;
    logic                rd_last_reg;
    logic                rd_stop_reg;
    logic                m_valid_reg;
    logic [PCM_W-1:0]    pcm_reg;
    logic                run_last_reg;
    logic                ustart_reg;
    logic                uend_reg;

    logic                accept;
    logic                block_end;
    logic [CW-1:0]       block_len;
    logic                issue;
    logic                issue_last;
    logic                out_load;
    logic [SAMPLE_W-1:0] rd_data;
    gate_dec_t           dec;

    // Input handshake and block boundary.
    assign s_ready   = (state_reg == ST_CAPTURE);
    assign accept    = s_valid && s_ready;
    assign block_end = s_block_last || (fill_reg == AW'(BLOCK_MAX - 1));
    assign block_len = CW'(fill_reg) + CW'(1);

    // Replay read issue: the read stage must be free or move on this cycle.
    assign out_load   = rd_valid_reg && (!m_valid_reg || m_ready);
    assign issue      = (state_reg == ST_REPLAY) && (!rd_valid_reg || out_load);
    assign issue_last = (CW'(rd_idx_reg) + CW'(1)) == len_reg;

    vag_store #(
        .BLOCK_MAX(BLOCK_MAX),
        .AW       (AW)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (accept),
        .wr_addr(fill_reg),
        .wr_data(s_sample_value),
        .rd_en  (issue),
        .rd_addr(rd_idx_reg),
        .rd_data(rd_data)
    );

    vag_gate #(
        .BLOCK_MAX(BLOCK_MAX),
        .CW       (CW)
    ) u_gate (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .sample_en(accept),
        .sample   (s_sample_value),
        .block_end(block_end),
        .block_len(block_len),
        .dec      (dec)
    );

    // Capture and replay sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CAPTURE;
            fill_reg   <= '0;
            rd_idx_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_CAPTURE: begin
                    if (accept) begin
                        if (block_end) begin
                            fill_reg   <= '0;
                            rd_idx_reg <= '0;
                            if (dec.keep) begin
                                state_reg <= ST_REPLAY;
                            end
                        end else begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                    end
                end
                ST_REPLAY: begin
                    if (issue) begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                        if (issue_last) begin
                            state_reg <= ST_CAPTURE;
                        end
                    end
                end
                default: state_reg <= ST_CAPTURE;
            endcase
        end
    end

    // Block length and flags latched at the decision.
    always_ff @(posedge aclk) begin
        if (accept && block_end) begin
            len_reg   <= block_len;
            start_reg <= dec.started;
            stop_reg  <= dec.stopped;
        end
    end

    // Read stage valid and per-sample flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (issue) begin
            rd_valid_reg <= 1'b1;
        end else if (out_load) begin
            rd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_first_reg <= start_reg && (rd_idx_reg == '0);
            rd_last_reg  <= issue_last;
            rd_stop_reg  <= stop_reg && issue_last;
        end
    end

    // Output register with PCM conversion.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            pcm_reg      <= to_pcm(rd_data);
            run_last_reg <= rd_last_reg;
            ustart_reg   <= rd_first_reg;
            uend_reg     <= rd_stop_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_pcm_sample      = pcm_reg;
    assign m_run_last        = run_last_reg;
    assign m_utterance_start = ustart_reg;
    assign m_utterance_end   = uend_reg;

    // A held read stage is never overwritten by a new store read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg && !out_load |-> !issue)
        else $error("vag core: read stage overwritten");

    // Capture and replay never overlap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !issue)
        else $error("vag core: store read while capturing");

    // The end of an utterance comes only on the last sample of a block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_utterance_end |-> m_run_last)
        else $error("vag core: utterance end away from block end");

    // A kept block always replays at least one sample.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_REPLAY |-> len_reg != '0)
        else $error("vag core: replay of an empty block");

endmodule

@@ design/vag_store.sv @@
// Block store: one write port and one registered read port.
// Depends on vag_pkg for the sample width.
`timescale 1ns / 1ps

module vag_store
    import vag_pkg::*;
#(
    parameter int BLOCK_MAX = BLOCK_MAX_DEF,
    parameter int AW = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [BLOCK_MAX];
    logic [SAMPLE_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data register holds between reads.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/vag_gate.sv @@
// Voice decision state: configuration registers, block peak, recording flag
// and saturating silence count. Depends on vag_pkg for widths and codes.
`timescale 1ns / 1ps

module vag_gate
    import vag_pkg::*;
#(
    parameter int BLOCK_MAX = BLOCK_MAX_DEF,
    parameter int CW = $clog2(BLOCK_MAX + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 sample_en,
    input  logic [SAMPLE_W-1:0]  sample,
    input  logic                 block_end,
    input  logic [CW-1:0]        block_len,
    output gate_dec_t            dec
);

    logic [CFG_W-1:0]    threshold_reg;
    logic [CFG_W-1:0]    limit_reg;
    logic [SAMPLE_W-1:0] peak_reg;
    logic [SAMPLE_W-1:0] peak_next;
    logic                rec_reg;
    logic                rec_next;
    logic [CFG_W-1:0]    silence_reg;
    logic [CFG_W-1:0]    silence_next;
    logic [SAMPLE_W-1:0] mag;
    logic [CFG_W:0]      sum;
    logic [CFG_W-1:0]    sum_sat;
    logic                voice;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            limit_reg     <= SILENCE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_THRESHOLD:     threshold_reg <= cfg_wdata;
                CFG_SILENCE_LIMIT: limit_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Magnitude of the incoming sample and the running peak.
    always_comb begin
        mag       = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
        peak_next = (mag > peak_reg) ? mag : peak_reg;
    end

    // End-of-block decision.
    always_comb begin
        voice        = peak_next > threshold_reg;
        sum          = {1'b0, silence_reg} + (CFG_W + 1)'(block_len);
        sum_sat      = sum[CFG_W] ? SILENCE_SAT : sum[CFG_W-1:0];
        dec          = '0;
        rec_next     = rec_reg;
        silence_next = silence_reg;
        if (voice) begin
            dec.keep     = 1'b1;
            dec.started  = !rec_reg;
            rec_next     = 1'b1;
            silence_next = '0;
        end else if (rec_reg) begin
            dec.keep     = 1'b1;
            silence_next = sum_sat;
            if (sum_sat >= limit_reg) begin
                dec.stopped  = 1'b1;
                rec_next     = 1'b0;
                silence_next = '0;
            end
        end
    end

    // State update on each accepted sample.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg    <= '0;
            rec_reg     <= 1'b0;
            silence_reg <= '0;
        end else if (sample_en) begin
            if (block_end) begin
                peak_reg    <= '0;
                rec_reg     <= rec_next;
                silence_reg <= silence_next;
            end else begin
                peak_reg <= peak_next;
            end
        end
    end

    // A block starts and stops a recording never at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        sample_en && block_end |-> !(dec.started && dec.stopped))
        else $error("vag_gate: start and stop in the same block");

    // The silence count is clear whenever recording is off.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !rec_reg |-> silence_reg == '0)
        else $error("vag_gate: silence count left over outside a recording");

    // A started block leaves recording on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        sample_en && block_end && dec.started |=> rec_reg)
        else $error("vag_gate: recording did not start");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for voice_activity_recording_gate_core: random and directed
// sample blocks, a built-in predictor of the gate decision and PCM replay, phased idling.
// Depends on vag_pkg and the design files of the gate.
`timescale 1ns / 1ps

module tb_top;
    import vag_pkg::*;

    localparam int BLOCK_LEN     = BLOCK_MAX_DEF;
    localparam int Q_ONE         = 1 << 20;
    localparam int PCM_GAIN      = 32767;
    localparam int PEAK_TOP      = 1 << 23;
    localparam int MAX_CYCLES    = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 20;
    localparam int PHASE_ITEMS   = 42;

    // Indexes outside the register list; writes to them must have no effect.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_INDEX   = 8'hFF;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
    } audio_item_t;

    typedef struct packed {
        logic signed [PCM_W-1:0] pcm;
        logic                    run_last;
        logic                    utt_start;
        logic                    utt_end;
    } pcm_word_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_wdata = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_value = '0;
    logic                       s_block_last = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [PCM_W-1:0]    m_pcm_sample;
    logic                       m_run_last;
    logic                       m_utterance_start;
    logic                       m_utterance_end;

    // Stimulus and expectation stores.
    audio_item_t audio_q[$];
    pcm_word_t   pcm_expect_q[$];
    int          items_queued = 0;
    int          items_accepted = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          gen_thr = 104858;
    logic        in_accept = 1'b0;

    // Predictor copy of the gate state and its registers.
    logic [SAMPLE_W-1:0] cap_store [BLOCK_LEN];
    int                  cap_fill;
    int                  cap_peak;
    logic                rec_on;
    int                  quiet_count;
    int                  thr_reg;
    int                  limit_reg;

    voice_activity_recording_gate_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample_value    (s_sample_value),
        .s_block_last      (s_block_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pcm_sample      (m_pcm_sample),
        .m_run_last        (m_run_last),
        .m_utterance_start (m_utterance_start),
        .m_utterance_end   (m_utterance_end)
    );

    always #2 aclk = ~aclk;

    // Clamp to [-1, 1] in Q4.20, scale to full-range PCM, truncate toward zero.
    function automatic logic signed [PCM_W-1:0] scale_to_pcm(
        input logic signed [SAMPLE_W-1:0] value);
        int     s;
        longint prod;
        longint q;
        s = value;
        if (s > Q_ONE) begin
            s = Q_ONE;
        end else if (s < -Q_ONE) begin
            s = -Q_ONE;
        end
        prod = longint'(s) * PCM_GAIN;
        q = prod / Q_ONE;
        return q[PCM_W-1:0];
    endfunction

    // Store one sample; at the end of a block decide keep/start/stop and queue its PCM.
    task automatic capture_and_decide(input logic signed [SAMPLE_W-1:0] value,
                                      input logic mark);
        int        mag;
        int        n;
        int        k;
        logic      keep;
        logic      started;
        logic      stopped;
        pcm_word_t w;
        cap_store[cap_fill] = value;
        cap_fill++;
        mag = (value < 0) ? -int'(value) : int'(value);
        if (mag > cap_peak) begin
            cap_peak = mag;
        end
        if (!mark && cap_fill < BLOCK_LEN) begin
            return;
        end
        n = cap_fill;
        keep = 1'b0;
        started = 1'b0;
        stopped = 1'b0;
        if (cap_peak > thr_reg) begin
            if (!rec_on) begin
                rec_on = 1'b1;
                started = 1'b1;
            end
            quiet_count = 0;
            keep = 1'b1;
        end else if (rec_on) begin
            quiet_count = quiet_count + n;
            if (quiet_count > int'(SILENCE_SAT)) begin
                quiet_count = int'(SILENCE_SAT);
            end
            keep = 1'b1;
            if (quiet_count >= limit_reg) begin
                rec_on = 1'b0;
                quiet_count = 0;
                stopped = 1'b1;
            end
        end
        cap_fill = 0;
        cap_peak = 0;
        if (keep) begin
            for (k = 0; k < n; k++) begin
                w.pcm = scale_to_pcm(cap_store[k]);
                w.run_last = (k == n - 1);
                w.utt_start = started && (k == 0);
                w.utt_end = stopped && (k == n - 1);
                pcm_expect_q.push_back(w);
            end
        end
    endtask

    // Check results, track register writes and predict every accepted sample.
    always @(posedge aclk) begin : check_proc
        pcm_word_t want;
        pcm_word_t got;
        if (!aresetn) begin
            cap_fill = 0;
            cap_peak = 0;
            rec_on = 1'b0;
            quiet_count = 0;
            thr_reg = int'(THRESHOLD_RESET);
            limit_reg = int'(SILENCE_RESET);
            in_accept = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_pcm_sample, m_run_last, m_utterance_start, m_utterance_end};
                if (pcm_expect_q.size() == 0) begin
                    $display("%0t: unexpected result pcm=%0d run_last=%b start=%b end=%b",
                             $time, got.pcm, got.run_last, got.utt_start, got.utt_end);
                    fail_count++;
                end else begin
                    want = pcm_expect_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected pcm=%0d run_last=%b start=%b end=%b",
                                 $time, want.pcm, want.run_last, want.utt_start,
                                 want.utt_end);
                        $display("%0t:          actual   pcm=%0d run_last=%b start=%b end=%b",
                                 $time, got.pcm, got.run_last, got.utt_start, got.utt_end);
                        fail_count++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_THRESHOLD: begin
                        thr_reg = int'(cfg_wdata);
                    end
                    CFG_SILENCE_LIMIT: begin
                        limit_reg = int'(cfg_wdata);
                    end
                    default: begin
                    end
                endcase
            end
            in_accept = s_valid && s_ready;
            if (in_accept) begin
                capture_and_decide(s_sample_value, s_block_last);
                items_accepted++;
            end
        end
    end

    // Present the next sample once the previous transaction completed; random gaps and stalls.
    always @(negedge aclk) begin : drive_proc
        audio_item_t nxt;
        if (!s_valid || in_accept) begin
            if (audio_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = audio_q.pop_front();
                s_valid <= 1'b1;
                s_sample_value <= nxt.value;
                s_block_last <= nxt.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic queue_sample(input logic signed [SAMPLE_W-1:0] value, input logic mark);
        audio_item_t item;
        item.value = value;
        item.last = mark;
        audio_q.push_back(item);
        items_queued++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] full_sample();
        logic [31:0] r;
        r = $urandom();
        return r[SAMPLE_W-1:0];
    endfunction

    // A sample whose magnitude does not exceed the current threshold.
    function automatic logic signed [SAMPLE_W-1:0] quiet_sample();
        int v;
        if (gen_thr >= PEAK_TOP) begin
            return full_sample();
        end
        v = int'($urandom_range(0, 2 * gen_thr)) - gen_thr;
        return v[SAMPLE_W-1:0];
    endfunction

    // A sample whose magnitude exceeds the threshold, often only just.
    function automatic logic signed [SAMPLE_W-1:0] loud_sample();
        int mag;
        int top;
        int v;
        top = PEAK_TOP;
        if ($urandom_range(0, 1) && gen_thr + Q_ONE < PEAK_TOP) begin
            top = gen_thr + Q_ONE;
        end
        mag = $urandom_range(gen_thr + 1, top);
        v = (mag == PEAK_TOP || $urandom_range(0, 1)) ? -mag : mag;
        return v[SAMPLE_W-1:0];
    endfunction

    // One block: mostly short ones, some that fill the store with or without a mark.
    task automatic queue_block();
        int   len;
        int   r;
        int   k;
        int   loud_pos;
        logic mark;
        logic loud;
        logic signed [SAMPLE_W-1:0] v;
        r = $urandom_range(0, 99);
        mark = 1'b1;
        if (r < 4) begin
            len = BLOCK_LEN;
            mark = 1'b0;
        end else if (r < 6) begin
            len = BLOCK_LEN;
        end else if (r < 10) begin
            len = $urandom_range(17, BLOCK_LEN - 1);
        end else begin
            len = $urandom_range(1, 8);
        end
        loud = (gen_thr < PEAK_TOP) && ($urandom_range(0, 99) < 45);
        loud_pos = $urandom_range(0, len - 1);
        for (k = 0; k < len; k++) begin
            if (loud && k == loud_pos) begin
                v = loud_sample();
            end else if (loud && $urandom_range(0, 1)) begin
                v = full_sample();
            end else begin
                v = quiet_sample();
            end
            queue_sample(v, mark && (k == len - 1));
        end
    endtask

    // Hold off the sender until every accepted sample has produced its results.
    task automatic drain_and_settle(input int extra);
        while (items_accepted != items_queued || pcm_expect_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] data);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
    endtask

    // Both registers, plus writes to unused indexes that must be ignored.
    task automatic program_registers(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] lim);
        write_register(CFG_THRESHOLD, thr);
        write_register(CFG_SPARE_INDEX, '0);
        write_register(CFG_SILENCE_LIMIT, lim);
        write_register(CFG_TOP_INDEX, '1);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER: begin
                send_idle_pct = 61;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                recv_stall_pct = 61;
            end
            IDLE_BOTH: begin
                send_idle_pct = 23;
                recv_stall_pct = 23;
            end
            default: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    task automatic run_phase(input int thr, input int lim, input idle_mode_t mode);
        int start_count;
        drain_and_settle(SETTLE_CYCLES);
        program_registers(thr[CFG_W-1:0], lim[CFG_W-1:0]);
        set_idle(mode);
        gen_thr = thr;
        start_count = items_queued;
        while (items_queued - start_count < PHASE_ITEMS) begin
            queue_block();
        end
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset register values.
        set_idle(IDLE_NONE);
        // Quiet block while not recording: dropped.
        queue_sample(24'sd0, 1'b1);
        // Peak equal to the threshold is not voice.
        queue_sample(24'sd104858, 1'b1);
        // Just above the threshold: recording starts on a one-sample block.
        queue_sample(-24'sd104859, 1'b1);
        // Field extremes and the clamp boundaries around +/-1.0.
        queue_sample(24'sd8388607, 1'b0);
        queue_sample(-24'sd8388608, 1'b0);
        queue_sample(24'sd1048576, 1'b0);
        queue_sample(-24'sd1048576, 1'b0);
        queue_sample(24'sd1048577, 1'b0);
        queue_sample(-24'sd1048577, 1'b0);
        queue_sample(24'sd1, 1'b0);
        queue_sample(-24'sd1, 1'b0);
        queue_sample(24'sd32, 1'b0);
        queue_sample(-24'sd32, 1'b0);
        queue_sample(24'sd0, 1'b1);
        // Quiet block while recording: kept, silence count grows.
        queue_sample(24'sd104858, 1'b0);
        queue_sample(-24'sd104858, 1'b0);
        queue_sample(24'sd1000, 1'b1);
        // Largest negative sample alone.
        queue_sample(-24'sd8388608, 1'b1);

        // Random phases over a range of register settings, extremes included.
        run_phase(0, 0, IDLE_NONE);
        run_phase(104858, 64, IDLE_SENDER);
        run_phase(8388607, 200, IDLE_RECEIVER);
        run_phase(8388608, 16777215, IDLE_BOTH);
        run_phase(300000, 1, IDLE_NONE);
        run_phase(50000, 120, IDLE_SENDER);
        run_phase(1000, 40, IDLE_RECEIVER);
        run_phase(2000000, 500, IDLE_BOTH);

        drain_and_settle(END_CYCLES);
        if (fail_count == 0 && pcm_expect_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/vag_pkg.sv
design/vag_store.sv
design/vag_gate.sv
design/voice_activity_recording_gate_core.sv
tb/tb_top.sv
